// File: rtl/mbs_pkg.sv
// ----------------------------------------------------------------------------
// mbs_pkg
// Shared sizes, codes and controller/datapath link types for the mean
// background subtraction core.
// ----------------------------------------------------------------------------
`default_nettype none

package mbs_pkg;

   localparam int MAX_PIXELS = 65536;
   localparam int MAX_FRAMES = 4096;

   localparam int INDEX_W = 16;
   localparam int COLOUR_W = 8;
   localparam int GRAY_W = 8;
   localparam int THRESH_W = 8;
   localparam int OP_W = 2;

   localparam int ADDR_W = $clog2(MAX_PIXELS);
   localparam int CNT_W = $clog2(MAX_FRAMES + 1);
   localparam int SUM_W = $clog2(MAX_FRAMES * 255 + 1);
   localparam int WIDE_W = SUM_W + CNT_W;
   localparam int QUOT_W = 8;
   localparam int STEP_W = $clog2(QUOT_W);
   localparam int GRAY_ACC_W = 16;

   localparam int GRAY_B_WT = 29;
   localparam int GRAY_G_WT = 150;
   localparam int GRAY_R_WT = 77;
   localparam int GRAY_ROUND = 128;

   localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(30);
   localparam logic [GRAY_W-1:0] BG_MAX = GRAY_W'(255);

   typedef enum logic [OP_W-1:0] {
      OP_ACCUMULATE = 2'd0,
      OP_SUBTRACT   = 2'd1,
      OP_CLEAR      = 2'd2,
      OP_NONE       = 2'd3
   } op_type;

   typedef struct packed {
      logic accept;
      logic clr_begin;
      logic clr_step;
      logic acc_write;
      logic div_load;
      logic div_step;
      logic fin;
      logic out_load;
   } mbs_cmd_type;

   typedef struct packed {
      logic clr_last;
      logic div_last;
      logic out_free;
   } mbs_sts_type;

endpackage

`default_nettype wire

// File: rtl/mbs_channels.sv
// ----------------------------------------------------------------------------
// mbs channels
// Valid/ready channel interfaces for pixel requests, mask responses and the
// threshold register write.
// ----------------------------------------------------------------------------
`default_nettype none

interface mbs_req_if;
   logic                valid;
   logic                ready;
   logic [1:0]          operation;
   logic [15:0]         pixel_index;
   logic [7:0]          blue;
   logic [7:0]          green;
   logic [7:0]          red;
   logic                frame_end;

   modport source (output valid, operation, pixel_index, blue, green, red, frame_end,
                   input ready);
   modport sink   (input valid, operation, pixel_index, blue, green, red, frame_end,
                   output ready);
endinterface

interface mbs_rsp_if;
   logic                valid;
   logic                ready;
   logic [15:0]         out_index;
   logic                foreground;
   logic                out_frame_end;

   modport source (output valid, out_index, foreground, out_frame_end, input ready);
   modport sink   (input valid, out_index, foreground, out_frame_end, output ready);
endinterface

interface mbs_csr_if;
   logic                valid;
   logic                ready;
   logic [7:0]          threshold;

   modport source (output valid, threshold, input ready);
   modport sink   (input valid, threshold, output ready);
endinterface

`default_nettype wire

// File: rtl/mean_background_subtraction_core.sv
// ----------------------------------------------------------------------------
// mean_background_subtraction_core
// Per-pixel running gray sums with mean background and threshold mask.
// ----------------------------------------------------------------------------
//  channel    dir  beat contents
//  req_port   in   operation, pixel_index, blue, green, red, frame_end
//  rsp_port   out  out_index, foreground, out_frame_end (subtract only)
//  csr_port   in   threshold (reset 30)
//
//  Accumulate reads the sum, then writes it back; subtract runs a restoring
//  divider producing one quotient bit a cycle.
//  Clear and reset run a clearing pass over the whole sum memory, one entry
//  a cycle, with req_port not ready. csr_port is always ready.
//  A finished mask beat waits in the output register; a stalled rsp_port
//  holds a subtract in its final state only while that register is full.
// ----------------------------------------------------------------------------
`default_nettype none

module mean_background_subtraction_core
   import mbs_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   mbs_req_if.sink    req_port,
   mbs_rsp_if.source  rsp_port,
   mbs_csr_if.sink    csr_port
);

   mbs_cmd_type cmd;
   mbs_sts_type sts;

   assign csr_port.ready = 1'b1;

   mbs_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_port.valid),
      .req_operation (req_port.operation),
      .req_ready     (req_port.ready),
      .sts           (sts),
      .cmd           (cmd)
   );

   mbs_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_pixel_index   (req_port.pixel_index),
      .req_blue          (req_port.blue),
      .req_green         (req_port.green),
      .req_red           (req_port.red),
      .req_frame_end     (req_port.frame_end),
      .csr_valid         (csr_port.valid),
      .csr_threshold     (csr_port.threshold),
      .rsp_valid         (rsp_port.valid),
      .rsp_ready         (rsp_port.ready),
      .rsp_out_index     (rsp_port.out_index),
      .rsp_foreground    (rsp_port.foreground),
      .rsp_out_frame_end (rsp_port.out_frame_end)
   );

endmodule

`default_nettype wire

// File: rtl/mbs_ram.sv
// ----------------------------------------------------------------------------
// mbs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mbs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/mbs_ctrl.sv
// ----------------------------------------------------------------------------
// mbs_ctrl
// Sequencer: clearing pass, request intake, accumulate write-back, divider
// steps and response hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module mbs_ctrl
   import mbs_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic [OP_W-1:0]   req_operation,
   output      logic              req_ready,
   input  wire mbs_sts_type       sts,
   output      mbs_cmd_type       cmd
);

   typedef enum logic [6:0] {
      S_CLEAR = 7'b0000001,
      S_IDLE  = 7'b0000010,
      S_ACC   = 7'b0000100,
      S_LOAD  = 7'b0001000,
      S_DIV   = 7'b0010000,
      S_FIN   = 7'b0100000,
      S_OUT   = 7'b1000000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               case (op_type'(req_operation))
                  OP_ACCUMULATE: state_in = S_ACC;
                  OP_SUBTRACT:   state_in = S_LOAD;
                  OP_CLEAR: begin
                     cmd.clr_begin = 1'b1;
                     state_in = S_CLEAR;
                  end
                  default:       state_in = S_IDLE;
               endcase
            end
         end
         S_ACC: begin
            cmd.acc_write = 1'b1;
            state_in = S_IDLE;
         end
         S_LOAD: begin
            cmd.div_load = 1'b1;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            cmd.fin = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            // hold until the output register can take the beat
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// File: rtl/mbs_dp.sv
// ----------------------------------------------------------------------------
// mbs_dp
// Datapath: gray conversion, sum memory read-modify-write, frame counter,
// restoring divider for the mean, threshold compare and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mbs_dp
   import mbs_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire mbs_cmd_type           cmd,
   output      mbs_sts_type           sts,
   input  wire logic [INDEX_W-1:0]    req_pixel_index,
   input  wire logic [COLOUR_W-1:0]   req_blue,
   input  wire logic [COLOUR_W-1:0]   req_green,
   input  wire logic [COLOUR_W-1:0]   req_red,
   input  wire logic                  req_frame_end,
   input  wire logic                  csr_valid,
   input  wire logic [THRESH_W-1:0]   csr_threshold,
   output      logic                  rsp_valid,
   input  wire logic                  rsp_ready,
   output      logic [INDEX_W-1:0]    rsp_out_index,
   output      logic                  rsp_foreground,
   output      logic                  rsp_out_frame_end
);

   logic [THRESH_W-1:0] threshold_ff;
   logic [INDEX_W-1:0]  idx_ff;
   logic                last_ff;
   logic [GRAY_W-1:0]   gray_ff;
   logic [CNT_W-1:0]    count_ff;
   logic [ADDR_W-1:0]   clr_addr_ff;
   logic [SUM_W-1:0]    rem_ff;
   logic [QUOT_W-1:0]   quot_ff;
   logic [STEP_W-1:0]   step_ff;
   logic                zero_ff;
   logic                sat_ff;
   logic [GRAY_W-1:0]   bg_ff;
   logic                rsp_valid_ff;
   logic [INDEX_W-1:0]  out_index_ff;
   logic                foreground_ff;
   logic                out_frame_end_ff;

   logic [GRAY_ACC_W-1:0] gray_acc;
   logic [GRAY_W-1:0]     gray_in;
   logic [SUM_W-1:0]      rd_data;
   logic                  wr_en;
   logic [ADDR_W-1:0]     wr_addr;
   logic [SUM_W-1:0]      wr_data;
   logic                  count_ok;
   logic [WIDE_W-1:0]     div_sub;
   logic                  div_fits;
   logic [WIDE_W-1:0]     rem_twice;
   logic                  round_up;
   logic [QUOT_W:0]       quot_round;
   logic [GRAY_W-1:0]     bg_in;
   logic [GRAY_W-1:0]     diff;

   // Rec.601 weights, rounded
   assign gray_acc = GRAY_ACC_W'(GRAY_B_WT) * GRAY_ACC_W'(req_blue)
                   + GRAY_ACC_W'(GRAY_G_WT) * GRAY_ACC_W'(req_green)
                   + GRAY_ACC_W'(GRAY_R_WT) * GRAY_ACC_W'(req_red)
                   + GRAY_ACC_W'(GRAY_ROUND);
   assign gray_in = gray_acc[GRAY_ACC_W-1 -: GRAY_W];

   assign count_ok = count_ff < CNT_W'(MAX_FRAMES);

   assign wr_en   = cmd.clr_step | (cmd.acc_write & count_ok);
   assign wr_addr = cmd.clr_step ? clr_addr_ff : idx_ff[ADDR_W-1:0];
   assign wr_data = cmd.clr_step ? '0 : rd_data + SUM_W'(gray_ff);

   mbs_ram #(
      .WIDTH (SUM_W),
      .DEPTH (MAX_PIXELS)
   ) u_sums (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (req_pixel_index[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   // restoring division, one quotient bit per step
   assign div_sub  = WIDE_W'(count_ff) << step_ff;
   assign div_fits = WIDE_W'(rem_ff) >= div_sub;

   // half to even on the final remainder
   assign rem_twice  = WIDE_W'(rem_ff) << 1;
   assign round_up   = (rem_twice > WIDE_W'(count_ff))
                     | ((rem_twice == WIDE_W'(count_ff)) & quot_ff[0]);
   assign quot_round = {1'b0, quot_ff} + (QUOT_W+1)'(round_up);

   always_comb begin
      if (zero_ff) begin
         bg_in = '0;
      end else if (sat_ff || quot_round[QUOT_W]) begin
         bg_in = BG_MAX;
      end else begin
         bg_in = quot_round[GRAY_W-1:0];
      end
   end

   assign diff = (gray_ff > bg_ff) ? gray_ff - bg_ff : bg_ff - gray_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESH_RESET;
         count_ff     <= '0;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            threshold_ff <= csr_threshold;
         end
         if (cmd.clr_begin) begin
            count_ff    <= '0;
            clr_addr_ff <= '0;
         end else if (cmd.clr_step) begin
            clr_addr_ff <= clr_addr_ff + ADDR_W'(1);
         end else if (cmd.acc_write && count_ok && last_ff) begin
            count_ff <= count_ff + CNT_W'(1);
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         idx_ff  <= req_pixel_index;
         last_ff <= req_frame_end;
         gray_ff <= gray_in;
      end
      if (cmd.div_load) begin
         rem_ff  <= rd_data;
         quot_ff <= '0;
         step_ff <= STEP_W'(QUOT_W - 1);
         zero_ff <= count_ff == '0;
         sat_ff  <= WIDE_W'(rd_data) >= (WIDE_W'(count_ff) << QUOT_W);
      end else if (cmd.div_step) begin
         if (div_fits) begin
            rem_ff <= SUM_W'(WIDE_W'(rem_ff) - div_sub);
            quot_ff[step_ff] <= 1'b1;
         end
         step_ff <= step_ff - STEP_W'(1);
      end
      if (cmd.fin) begin
         bg_ff <= bg_in;
      end
      if (cmd.out_load) begin
         out_index_ff     <= idx_ff;
         foreground_ff    <= diff > threshold_ff;
         out_frame_end_ff <= last_ff;
      end
   end

   assign sts.clr_last = clr_addr_ff == '1;
   assign sts.div_last = step_ff == '0;
   assign sts.out_free = ~rsp_valid_ff | rsp_ready;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_index     = out_index_ff;
   assign rsp_foreground    = foreground_ff;
   assign rsp_out_frame_end = out_frame_end_ff;

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Mean background subtraction core testbench
// Drives pixel beats through the request channel and checks every mask beat
// against a cycle-free model of the per-pixel gray sums and frame count.
// A directed opener is followed by a frame-count sweep and four random phases.
// Each phase runs under a new threshold.
// ----------------------------------------------------------------------------

module tb;
   import mbs_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 6_000_000;
   localparam int unsigned PHASE_BEATS = 290;

   typedef struct packed {
      op_type               operation;
      logic [INDEX_W-1:0]   pixel_index;
      logic [COLOUR_W-1:0]  blue;
      logic [COLOUR_W-1:0]  green;
      logic [COLOUR_W-1:0]  red;
      logic                 frame_end;
   } pixel_beat_type;

   typedef struct packed {
      logic [INDEX_W-1:0] out_index;
      logic               foreground;
      logic               out_frame_end;
   } mask_beat_type;

   logic clock;
   logic reset;

   mbs_req_if req_bus();
   mbs_rsp_if rsp_bus();
   mbs_csr_if csr_bus();

   mean_background_subtraction_core u_top (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus),
      .csr_port (csr_bus)
   );

   // model state
   int unsigned          gray_sum [int unsigned];
   int unsigned          frames_seen;
   logic [THRESH_W-1:0]  thresh_now = THRESH_RESET;

   pixel_beat_type pixel_queue[$];
   mask_beat_type  expected_masks[$];

   int unsigned beats_issued;
   int unsigned ignored_issued;
   int unsigned beats_accepted;
   int unsigned masks_checked;
   int unsigned masks_moving;
   int unsigned capped_beats;
   int unsigned fail_count;
   int unsigned cycle_count;

   logic        req_taken;
   int unsigned req_gap;
   int unsigned req_calm;
   int unsigned rsp_stall;
   int unsigned rsp_calm;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int unsigned gray_level(logic [7:0] b, logic [7:0] g, logic [7:0] r);
      int unsigned acc;
      acc = GRAY_B_WT * b + GRAY_G_WT * g + GRAY_R_WT * r + GRAY_ROUND;
      return acc >> 8;
   endfunction

   // mean rounded half to even, clipped to the gray range
   function automatic int unsigned mean_background(int unsigned sum, int unsigned frames);
      int unsigned q;
      int unsigned rem;
      if (frames == 0) return 0;
      q = sum / frames;
      rem = sum % frames;
      if (rem > frames - rem || (rem == frames - rem && q[0])) q++;
      return (q > 255) ? 255 : q;
   endfunction

   function automatic void apply_pixel_beat(pixel_beat_type beat);
      int unsigned   gray;
      int unsigned   sum;
      int unsigned   bg;
      int unsigned   diff;
      mask_beat_type m;
      gray = gray_level(beat.blue, beat.green, beat.red);
      case (beat.operation)
         OP_ACCUMULATE: begin
            if (frames_seen < MAX_FRAMES) begin
               sum = gray_sum.exists(beat.pixel_index) ? gray_sum[beat.pixel_index] : 0;
               gray_sum[beat.pixel_index] = sum + gray;
               if (beat.frame_end) frames_seen++;
            end else begin
               capped_beats++;
            end
         end
         OP_SUBTRACT: begin
            sum = gray_sum.exists(beat.pixel_index) ? gray_sum[beat.pixel_index] : 0;
            bg = mean_background(sum, frames_seen);
            diff = (gray > bg) ? gray - bg : bg - gray;
            m.out_index = beat.pixel_index;
            m.foreground = (diff > thresh_now);
            m.out_frame_end = beat.frame_end;
            expected_masks = {expected_masks, m};
         end
         OP_CLEAR: begin
            gray_sum.delete();
            frames_seen = 0;
         end
         default: ;
      endcase
   endfunction

   // mostly short pauses, a few long ones, and calm stretches with none
   function automatic int unsigned pause_len(ref int unsigned calm);
      int unsigned r;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
         calm = $urandom_range(20, 60);
         return 0;
      end
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // request driver: hold until the beat is taken, then advance
   always @(negedge clock) begin
      pixel_beat_type nxt;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_taken) begin
         if (req_gap > 0) begin
            req_gap--;
            req_bus.valid <= 1'b0;
         end else if (pixel_queue.size() > 0) begin
            nxt = pixel_queue.pop_front();
            req_bus.valid       <= 1'b1;
            req_bus.operation   <= nxt.operation;
            req_bus.pixel_index <= nxt.pixel_index;
            req_bus.blue        <= nxt.blue;
            req_bus.green       <= nxt.green;
            req_bus.red         <= nxt.red;
            req_bus.frame_end   <= nxt.frame_end;
            req_gap = pause_len(req_calm);
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // response back-pressure
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
         if ($urandom_range(0, 3) == 0) rsp_stall = pause_len(rsp_calm);
      end
   end

   always @(posedge clock) begin
      mask_beat_type  want;
      pixel_beat_type seen;
      if (reset) begin
         req_taken <= 1'b0;
         gray_sum.delete();
         frames_seen = 0;
         thresh_now = THRESH_RESET;
      end else begin
         req_taken <= req_bus.valid && req_bus.ready;
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_masks.size() == 0) begin
               $error("mask beat for index %0d with nothing expected", rsp_bus.out_index);
               fail_count++;
            end else begin
               want = expected_masks.pop_front();
               masks_checked++;
               if (rsp_bus.foreground === 1'b1) masks_moving++;
               if (rsp_bus.out_index !== want.out_index) begin
                  $error("out_index: expected %0d, actual %0d", want.out_index,
                         rsp_bus.out_index);
                  fail_count++;
               end
               if (rsp_bus.foreground !== want.foreground) begin
                  $error("foreground: expected %0d, actual %0d", want.foreground,
                         rsp_bus.foreground);
                  fail_count++;
               end
               if (rsp_bus.out_frame_end !== want.out_frame_end) begin
                  $error("out_frame_end: expected %0d, actual %0d", want.out_frame_end,
                         rsp_bus.out_frame_end);
                  fail_count++;
               end
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            seen.operation   = op_type'(req_bus.operation);
            seen.pixel_index = req_bus.pixel_index;
            seen.blue        = req_bus.blue;
            seen.green       = req_bus.green;
            seen.red         = req_bus.red;
            seen.frame_end   = req_bus.frame_end;
            apply_pixel_beat(seen);
            beats_accepted++;
         end
         if (csr_bus.valid && csr_bus.ready) thresh_now = csr_bus.threshold;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $error("run exceeded %0d cycles", CYCLE_LIMIT);
         $display("Verification failed");
         $finish;
      end
   end

   task automatic push_beat(op_type op, int unsigned idx, logic [7:0] b, logic [7:0] g,
                            logic [7:0] r, logic last);
      pixel_beat_type beat;
      beat.operation   = op;
      beat.pixel_index = idx[INDEX_W-1:0];
      beat.blue        = b;
      beat.green       = g;
      beat.red         = r;
      beat.frame_end   = last;
      pixel_queue = {pixel_queue, beat};
      beats_issued++;
      if (op == OP_NONE) ignored_issued++;
   endtask

   function automatic logic [7:0] near_colour(logic [7:0] base, int spread);
      int v;
      v = int'(base) + int'($urandom_range(0, 2 * spread)) - spread;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return v[7:0];
   endfunction

   function automatic logic [7:0] any_colour();
      return 8'($urandom_range(0, 255));
   endfunction

   // wait until every beat is taken and every mask has come back
   task automatic settle();
      while (beats_accepted != beats_issued || expected_masks.size() != 0)
         @(negedge clock);
      repeat (16) @(negedge clock);
   endtask

   task automatic write_threshold(logic [7:0] value);
      csr_bus.valid     <= 1'b1;
      csr_bus.threshold <= value;
      do @(posedge clock); while (!csr_bus.ready);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   // a few frames of a small scene near fixed colours, then one mask frame
   task automatic run_scene();
      int unsigned npix;
      int unsigned base;
      int unsigned nframes;
      int          spread;
      logic [7:0]  bb [12];
      logic [7:0]  gg [12];
      logic [7:0]  rr [12];
      npix = $urandom_range(1, 12);
      base = ($urandom_range(0, 99) < 70) ? $urandom_range(0, 63)
                                          : $urandom_range(0, 65535 - npix);
      spread = ($urandom_range(0, 3) == 0) ? 40 : 6;
      nframes = $urandom_range(1, 5);
      for (int p = 0; p < npix; p++) begin
         bb[p] = any_colour();
         gg[p] = any_colour();
         rr[p] = any_colour();
      end
      for (int f = 0; f < nframes; f++)
         for (int p = 0; p < npix; p++)
            push_beat(OP_ACCUMULATE, base + p, near_colour(bb[p], spread),
                      near_colour(gg[p], spread), near_colour(rr[p], spread), p == npix - 1);
      for (int p = 0; p < npix; p++) begin
         if ($urandom_range(0, 1))
            push_beat(OP_SUBTRACT, base + p, near_colour(bb[p], spread),
                      near_colour(gg[p], spread), near_colour(rr[p], spread), p == npix - 1);
         else
            push_beat(OP_SUBTRACT, base + p, any_colour(), any_colour(), any_colour(),
                      p == npix - 1);
      end
   endtask

   // partial frame with no end mark, often the same pixel over and over
   task automatic run_broken();
      int unsigned idx;
      int unsigned n;
      n = $urandom_range(1, 6);
      idx = $urandom_range(0, 63);
      for (int k = 0; k < n; k++)
         push_beat(OP_ACCUMULATE, ($urandom_range(0, 1)) ? idx : $urandom_range(0, 63),
                   any_colour(), any_colour(), any_colour(), 1'b0);
      push_beat(OP_SUBTRACT, idx, any_colour(), any_colour(), any_colour(),
                1'($urandom_range(0, 1)));
   endtask

   task automatic run_noise();
      op_type op;
      int unsigned n;
      n = $urandom_range(1, 6);
      for (int k = 0; k < n; k++) begin
         case ($urandom_range(0, 5))
            0, 1:    op = OP_ACCUMULATE;
            2, 3, 4: op = OP_SUBTRACT;
            default: op = OP_NONE;
         endcase
         push_beat(op, $urandom_range(0, 65535), any_colour(), any_colour(), any_colour(),
                   1'($urandom_range(0, 1)));
      end
   endtask

   initial begin
      logic [7:0]  phase_thresh [4];
      int unsigned phase_start;
      int unsigned kind;

      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.operation = OP_ACCUMULATE;
      req_bus.pixel_index = '0;
      req_bus.blue = '0;
      req_bus.green = '0;
      req_bus.red = '0;
      req_bus.frame_end = 1'b0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.threshold = '0;
      beats_issued = 0;
      ignored_issued = 0;
      beats_accepted = 0;
      masks_checked = 0;
      masks_moving = 0;
      capped_beats = 0;
      fail_count = 0;
      cycle_count = 0;
      req_gap = 0;
      req_calm = 0;
      rsp_stall = 0;
      rsp_calm = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed opener under the reset threshold
      push_beat(OP_SUBTRACT, 0, 8'd0, 8'd0, 8'd0, 1'b0);          // empty count
      push_beat(OP_SUBTRACT, 65535, 8'd255, 8'd255, 8'd255, 1'b1); // mark copied only
      push_beat(OP_ACCUMULATE, 0, 8'd255, 8'd0, 8'd0, 1'b0);
      push_beat(OP_ACCUMULATE, 65535, 8'd0, 8'd255, 8'd0, 1'b1);
      push_beat(OP_ACCUMULATE, 5, 8'd0, 8'd0, 8'd255, 1'b1);
      push_beat(OP_ACCUMULATE, 7, 8'd255, 8'd255, 8'd255, 1'b0);
      push_beat(OP_ACCUMULATE, 7, 8'd255, 8'd255, 8'd255, 1'b0);
      push_beat(OP_ACCUMULATE, 7, 8'd255, 8'd255, 8'd255, 1'b0);
      push_beat(OP_SUBTRACT, 7, 8'd0, 8'd0, 8'd0, 1'b0);          // saturated background
      push_beat(OP_SUBTRACT, 0, 8'd255, 8'd0, 8'd0, 1'b0);
      push_beat(OP_SUBTRACT, 5, 8'd0, 8'd0, 8'd170, 1'b1);
      push_beat(OP_NONE, 0, 8'd255, 8'd255, 8'd255, 1'b1);        // ignored operation
      push_beat(OP_SUBTRACT, 65535, 8'd0, 8'd255, 8'd0, 1'b0);
      push_beat(OP_ACCUMULATE, 3, 8'd1, 8'd1, 8'd1, 1'b1);
      push_beat(OP_SUBTRACT, 3, 8'd0, 8'd0, 8'd0, 1'b1);
      push_beat(OP_CLEAR, 0, 8'd0, 8'd0, 8'd0, 1'b0);
      push_beat(OP_SUBTRACT, 7, 8'd0, 8'd0, 8'd0, 1'b0);          // sums gone after clear
      push_beat(OP_ACCUMULATE, 65535, 8'd128, 8'd128, 8'd128, 1'b1);
      push_beat(OP_SUBTRACT, 65535, 8'd128, 8'd128, 8'd128, 1'b1);

      // build a deep frame count over sixteen pixels
      settle();
      write_threshold(8'($urandom_range(20, 80)));
      push_beat(OP_CLEAR, 0, 8'd0, 8'd0, 8'd0, 1'b0);
      for (int k = 0; k < 200; k++)
         push_beat(OP_ACCUMULATE, $urandom_range(0, 15), any_colour(), any_colour(),
                   any_colour(), (k % 20) != 0);
      for (int p = 0; p < 16; p++)
         push_beat(OP_SUBTRACT, p, any_colour(), any_colour(), any_colour(), p == 15);

      phase_thresh[0] = 8'd0;
      phase_thresh[1] = 8'd255;
      phase_thresh[2] = 8'($urandom_range(1, 254));
      phase_thresh[3] = 8'($urandom_range(10, 60));
      for (int ph = 0; ph < 4; ph++) begin
         settle();
         write_threshold(phase_thresh[ph]);
         push_beat(OP_CLEAR, 0, 8'd0, 8'd0, 8'd0, 1'b0);
         phase_start = beats_issued - ignored_issued;
         while (beats_issued - ignored_issued - phase_start < PHASE_BEATS) begin
            kind = $urandom_range(0, 99);
            if (kind < 75) run_scene();
            else if (kind < 90) run_noise();
            else run_broken();
         end
         // close the phase on a mask beat so idle is observable
         push_beat(OP_SUBTRACT, $urandom_range(0, 63), any_colour(), any_colour(),
                   any_colour(), 1'b1);
      end

      settle();
      if (expected_masks.size() != 0) begin
         $error("%0d mask beats never arrived", expected_masks.size());
         fail_count++;
      end
      $display("Run covered %0d pixel beats, %0d mask beats checked (%0d moving),",
               beats_accepted, masks_checked, masks_moving);
      $display("%0d accumulates dropped at the frame limit, %0d cycles.", capped_beats,
               cycle_count);
      if (fail_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

// File: sim.f
rtl/mbs_pkg.sv
rtl/mbs_channels.sv
rtl/mbs_ram.sv
rtl/mbs_ctrl.sv
rtl/mbs_dp.sv
rtl/mean_background_subtraction_core.sv
tb/sv/tb.sv
